>>> sv/smvs_pkg.sv
// shared constants, codes and controller/datapath types of the mean and variance sampler
`default_nettype none
package smvs_pkg;

    localparam int LANES           = 3;
    localparam int RAW_BITS        = 16;
    localparam int MAX_SAMPLES_DEF = 1024;

    localparam int CNT_W    = 11;
    localparam int DISC_W   = 8;
    localparam int CHAN_W   = 2;
    localparam int GAIN_W   = 32;
    localparam int IDX_W    = 2;
    localparam int MEAN_W   = 48;
    localparam int VAR_W    = 63;

    // gain is Q2.30, results carry 16 fraction bits
    localparam int MEAN_SHIFT     = 14;
    localparam int VAR_SHIFT      = 44;
    localparam int VAR_HALF_SHIFT = 43;

    localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST  = CNT_W'(16);
    localparam logic [DISC_W-1:0] DISCARD_COUNT_RST = DISC_W'(10);
    localparam logic [CHAN_W-1:0] CHANNEL_COUNT_RST = CHAN_W'(3);
    localparam logic [GAIN_W-1:0] GAIN_RST          = 32'h4000_0000;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        CFG_SAMPLE_COUNT  = 2'd0,
        CFG_DISCARD_COUNT = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2,
        CFG_GAIN          = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_READ,
        DP_SUM_ACC,
        DP_SQ_DEV,
        DP_SQ_MST,
        DP_SQ_ACC,
        DP_MEAN_MST,
        DP_MEAN_DST,
        DP_MEAN_SAVE,
        DP_D_DST,
        DP_V_MST,
        DP_V_DST,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        logic   in_ready;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic close;
        logic k_end;
        logic lane_end;
        logic mul_busy;
        logic div_busy;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

>>> sv/smvs_if.sv
// item channels and configuration write channel
`default_nettype none
interface smvs_in_if import smvs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic signed [RAW_BITS-1:0] lane0_raw;
    logic signed [RAW_BITS-1:0] lane1_raw;
    logic signed [RAW_BITS-1:0] lane2_raw;
    modport source (output valid, operation, lane0_raw, lane1_raw, lane2_raw, input ready);
    modport sink (input valid, operation, lane0_raw, lane1_raw, lane2_raw, output ready);
endinterface

interface smvs_out_if import smvs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CHAN_W-1:0]        channel_index;
    logic signed [MEAN_W-1:0] scaled_mean;
    logic [VAR_W-1:0]         scaled_variance;
    logic                     last;
    modport source (output valid, channel_index, scaled_mean, scaled_variance, last,
                    input ready);
    modport sink (input valid, channel_index, scaled_mean, scaled_variance, last,
                  output ready);
endinterface

interface smvs_cfg_if import smvs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [GAIN_W-1:0] wdata;
    modport source (output valid, index, wdata, input ready);
    modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

>>> sv/smvs_ram.sv
// generic single write port ram with registered read
`default_nettype none
module smvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> sv/smvs_ctrl.sv
// sequencer for sample collection and the two-pass per-channel evaluation
`default_nettype none
module smvs_ctrl import smvs_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_SUM_RD, S_SUM_ACC, S_SQ_RD, S_SQ_DEV, S_SQ_MST, S_SQ_MUL, S_SQ_ACC,
        S_MEAN_MST, S_MEAN_MUL, S_MEAN_DST, S_MEAN_DIV, S_MEAN_SAVE, S_D_DST, S_D_DIV,
        S_V_MST, S_V_MUL, S_V_DST, S_V_DIV, S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (stat.close) state_next = S_SUM_RD;
            S_SUM_RD:    state_next = S_SUM_ACC;
            S_SUM_ACC:   state_next = stat.k_end ? S_SQ_RD : S_SUM_RD;
            S_SQ_RD:     state_next = S_SQ_DEV;
            S_SQ_DEV:    state_next = S_SQ_MST;
            S_SQ_MST:    state_next = S_SQ_MUL;
            S_SQ_MUL:    if (!stat.mul_busy) state_next = S_SQ_ACC;
            S_SQ_ACC:    state_next = stat.k_end ? S_MEAN_MST : S_SQ_RD;
            S_MEAN_MST:  state_next = S_MEAN_MUL;
            S_MEAN_MUL:  if (!stat.mul_busy) state_next = S_MEAN_DST;
            S_MEAN_DST:  state_next = S_MEAN_DIV;
            S_MEAN_DIV:  if (!stat.div_busy) state_next = S_MEAN_SAVE;
            S_MEAN_SAVE: state_next = S_D_DST;
            S_D_DST:     state_next = S_D_DIV;
            S_D_DIV:     if (!stat.div_busy) state_next = S_V_MST;
            S_V_MST:     state_next = S_V_MUL;
            S_V_MUL:     if (!stat.mul_busy) state_next = S_V_DST;
            S_V_DST:     state_next = S_V_DIV;
            S_V_DIV:     if (!stat.div_busy) state_next = S_OUT;
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.lane_end ? S_IDLE : S_SUM_RD;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.in_ready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_SUM_RD, S_SQ_RD: cmd.op = DP_READ;
            S_SUM_ACC:         cmd.op = DP_SUM_ACC;
            S_SQ_DEV:          cmd.op = DP_SQ_DEV;
            S_SQ_MST:          cmd.op = DP_SQ_MST;
            S_SQ_ACC:          cmd.op = DP_SQ_ACC;
            S_MEAN_MST:        cmd.op = DP_MEAN_MST;
            S_MEAN_DST:        cmd.op = DP_MEAN_DST;
            S_MEAN_SAVE:       cmd.op = DP_MEAN_SAVE;
            S_D_DST:           cmd.op = DP_D_DST;
            S_V_MST:           cmd.op = DP_V_MST;
            S_V_DST:           cmd.op = DP_V_DST;
            S_OUT:             cmd.op = DP_OUT;
            default:           cmd.op = DP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a wait on a unit always follows the cycle that started it
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQ_MST || state_reg == S_MEAN_MST || state_reg == S_V_MST)
        |=> stat.mul_busy || state_reg != S_IDLE)
        else $error("multiplier start left the sequence");
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.close |-> state_reg == S_IDLE)
        else $error("run closed outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && stat.out_free && stat.lane_end) |=> state_reg == S_IDLE)
        else $error("last channel did not end the run");
endmodule
`default_nettype wire

>>> sv/smvs_dpath.sv
// sample store, accumulators, serial multiplier, serial divider and result register
`default_nettype none
module smvs_dpath import smvs_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire dp_cmd_t cmd,
    output dp_stat_t     stat,
    smvs_in_if.sink      item,
    smvs_out_if.source   result,
    smvs_cfg_if.sink     cfg
);
    localparam int NW    = $clog2(MAX_SAMPLES + 1);
    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int SUM_W = RAW_BITS + NW;
    localparam int MAG_W = RAW_BITS + NW;
    localparam int DEV_W = MAG_W + 1;
    localparam int Q_W   = 2 * MAG_W + NW;
    localparam int MA_W  = 2 * GAIN_W;
    localparam int PR_W  = MA_W + Q_W;
    localparam int MP_W  = GAIN_W + SUM_W + 1;
    localparam int VX_W  = PR_W + 1 - VAR_SHIFT;
    localparam int DV_A  = (MP_W > Q_W) ? MP_W : Q_W;
    localparam int DV_B  = (DV_A > VX_W) ? DV_A : VX_W;
    localparam int DV_W  = (DV_B > 64) ? DV_B : 64;
    localparam int DS_W  = ((NW + MEAN_SHIFT) > 2 * NW) ? (NW + MEAN_SHIFT) : 2 * NW;
    localparam int DC_W  = $clog2(DV_W + 1);
    localparam int CW    = (NW > CNT_W) ? NW : CNT_W;

    // configuration
    logic [CNT_W-1:0]  samp_cnt_reg;
    logic [DISC_W-1:0] disc_cnt_reg;
    logic [CHAN_W-1:0] chan_cnt_reg;
    logic [GAIN_W-1:0] gain_reg;

    // run control
    logic              run_active_reg;
    logic [DISC_W-1:0] discard_left_reg;
    logic [NW-1:0]     kept_reg;
    logic [NW-1:0]     n_reg;
    logic [NW-1:0]     k_reg;
    logic [CHAN_W-1:0] lane_reg;

    // arithmetic
    logic signed [SUM_W-1:0] sum_reg;
    logic [Q_W-1:0]          q_reg;
    logic signed [DEV_W-1:0] dev_reg;
    logic [MA_W-1:0]         g2_reg;
    logic [2*NW-1:0]         den_v_reg;
    logic [PR_W-1:0]         ma_reg, pr_reg;
    logic [Q_W-1:0]          mb_reg;
    logic [DV_W-1:0]         dvd_reg;
    logic [DS_W-1:0]         rem_reg, ds_reg;
    logic [DC_W-1:0]         dcnt_reg;
    logic signed [MEAN_W-1:0] mean_reg;

    // result register
    logic                     out_valid_reg;
    logic [CHAN_W-1:0]        out_idx_reg;
    logic signed [MEAN_W-1:0] out_mean_reg;
    logic [VAR_W-1:0]         out_var_reg;
    logic                     out_last_reg;

    logic                        item_acc, keep, close, k_end, lane_end, out_free, out_load;
    logic                        mul_busy, div_busy;
    logic [NW-1:0]               kept_inc;
    logic [CW-1:0]               target;
    logic [CHAN_W-1:0]           chans;
    logic [LANES*RAW_BITS-1:0]   rd_data;
    logic signed [RAW_BITS-1:0]  x_lane;
    logic signed [DEV_W-1:0]     nx, sum_dev;
    logic [DEV_W-1:0]            dev_abs;
    logic [SUM_W-1:0]            sum_abs;
    logic [DS_W:0]               div_tmp;
    logic                        div_ge;
    logic [DS_W-1:0]             rem_next;
    logic [PR_W:0]               v_sum;
    logic [DV_W-1:0]             mean_dvd, v_dvd;
    logic [VAR_W-1:0]            var_sat;

    // ---------------- input side ----------------
    assign item.ready = cmd.in_ready;
    assign cfg.ready  = 1'b1;
    assign item_acc   = item.valid & item.ready;
    assign kept_inc   = kept_reg + NW'(1);
    assign keep       = item_acc && (item.operation == OP_SAMPLE) && run_active_reg
                        && (discard_left_reg == '0);

    always_comb
    begin
        if (samp_cnt_reg < CNT_W'(2))
        begin
            target = CW'(2);
        end
        else if (CW'(samp_cnt_reg) > CW'(MAX_SAMPLES))
        begin
            target = CW'(MAX_SAMPLES);
        end
        else
        begin
            target = CW'(samp_cnt_reg);
        end
    end

    assign close = keep && (CW'(kept_inc) >= target);

    always_comb
    begin
        if (chan_cnt_reg == '0)
        begin
            chans = CHAN_W'(1);
        end
        else if (chan_cnt_reg > CHAN_W'(LANES))
        begin
            chans = CHAN_W'(LANES);
        end
        else
        begin
            chans = chan_cnt_reg;
        end
    end

    assign k_end    = (k_reg == n_reg - NW'(1));
    assign lane_end = (lane_reg == chans - CHAN_W'(1));
    assign out_free = !out_valid_reg || result.ready;
    assign out_load = (cmd.op == DP_OUT) && out_free;

    smvs_ram #(
        .WIDTH (LANES * RAW_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (keep),
        .waddr (kept_reg[AW-1:0]),
        .wdata ({item.lane2_raw, item.lane1_raw, item.lane0_raw}),
        .re    (cmd.op == DP_READ),
        .raddr (k_reg[AW-1:0]),
        .rdata (rd_data)
    );

    assign x_lane  = rd_data[lane_reg*RAW_BITS +: RAW_BITS];
    assign nx      = $signed({{(DEV_W-NW){1'b0}}, n_reg})
                     * $signed({{(DEV_W-RAW_BITS){x_lane[RAW_BITS-1]}}, x_lane});
    assign sum_dev = $signed({{(DEV_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg});
    assign dev_abs = dev_reg[DEV_W-1] ? DEV_W'(-dev_reg) : DEV_W'(dev_reg);
    assign sum_abs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // ---------------- serial units ----------------
    assign mul_busy = (mb_reg != '0);
    assign div_busy = (dcnt_reg != '0);

    assign div_tmp  = {rem_reg, dvd_reg[DV_W-1]};
    assign div_ge   = (div_tmp >= {1'b0, ds_reg});
    assign rem_next = div_ge ? DS_W'(div_tmp - {1'b0, ds_reg}) : div_tmp[DS_W-1:0];

    // round to nearest by adding half the divisor ahead of the division
    assign mean_dvd = DV_W'(pr_reg[MP_W-2:0]) + (DV_W'(n_reg) << (MEAN_SHIFT - 1));
    assign v_sum    = {1'b0, pr_reg} + ((PR_W+1)'(den_v_reg) << VAR_HALF_SHIFT);
    assign v_dvd    = DV_W'(v_sum >> VAR_SHIFT);
    assign var_sat  = (|(dvd_reg >> VAR_W)) ? {VAR_W{1'b1}} : dvd_reg[VAR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samp_cnt_reg     <= SAMPLE_COUNT_RST;
            disc_cnt_reg     <= DISCARD_COUNT_RST;
            chan_cnt_reg     <= CHANNEL_COUNT_RST;
            gain_reg         <= GAIN_RST;
            run_active_reg   <= 1'b0;
            discard_left_reg <= '0;
            kept_reg         <= '0;
            n_reg            <= NW'(2);
            k_reg            <= '0;
            lane_reg         <= '0;
            mb_reg           <= '0;
            dcnt_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_SAMPLE_COUNT:  samp_cnt_reg <= cfg.wdata[CNT_W-1:0];
                    CFG_DISCARD_COUNT: disc_cnt_reg <= cfg.wdata[DISC_W-1:0];
                    CFG_CHANNEL_COUNT: chan_cnt_reg <= cfg.wdata[CHAN_W-1:0];
                    CFG_GAIN:          gain_reg     <= cfg.wdata;
                    default:           samp_cnt_reg <= samp_cnt_reg;
                endcase
            end

            if (item_acc)
            begin
                if (item.operation == OP_START)
                begin
                    kept_reg         <= '0;
                    discard_left_reg <= disc_cnt_reg;
                    run_active_reg   <= 1'b1;
                end
                else if (run_active_reg && discard_left_reg != '0)
                begin
                    discard_left_reg <= discard_left_reg - DISC_W'(1);
                end
                else if (keep)
                begin
                    kept_reg <= kept_inc;
                end
            end
            if (close)
            begin
                run_active_reg <= 1'b0;
                n_reg          <= kept_inc;
                k_reg          <= '0;
                lane_reg       <= '0;
            end

            if (cmd.op == DP_SUM_ACC || cmd.op == DP_SQ_ACC)
            begin
                k_reg <= k_end ? '0 : k_reg + NW'(1);
            end

            if (cmd.op == DP_SQ_MST)
            begin
                mb_reg <= Q_W'(dev_abs[MAG_W-1:0]);
            end
            else if (cmd.op == DP_MEAN_MST)
            begin
                mb_reg <= Q_W'(sum_abs);
            end
            else if (cmd.op == DP_V_MST)
            begin
                mb_reg <= dvd_reg[Q_W-1:0];
            end
            else if (mul_busy)
            begin
                mb_reg <= mb_reg >> 1;
            end

            if (cmd.op == DP_MEAN_DST || cmd.op == DP_D_DST || cmd.op == DP_V_DST)
            begin
                dcnt_reg <= DC_W'(DV_W);
            end
            else if (div_busy)
            begin
                dcnt_reg <= dcnt_reg - DC_W'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (!lane_end)
                begin
                    lane_reg <= lane_reg + CHAN_W'(1);
                    k_reg    <= '0;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        g2_reg    <= MA_W'(gain_reg) * MA_W'(gain_reg);
        den_v_reg <= (2*NW)'(n_reg) * (2*NW)'(n_reg - NW'(1));

        if (close || out_load)
        begin
            sum_reg <= '0;
            q_reg   <= '0;
        end
        else if (cmd.op == DP_SUM_ACC)
        begin
            sum_reg <= sum_reg + $signed({{(SUM_W-RAW_BITS){x_lane[RAW_BITS-1]}}, x_lane});
        end
        else if (cmd.op == DP_SQ_ACC)
        begin
            q_reg <= q_reg + pr_reg[Q_W-1:0];
        end

        if (cmd.op == DP_SQ_DEV)
        begin
            dev_reg <= nx - sum_dev;
        end

        // shift-and-add multiplier, one multiplier bit per cycle
        if (cmd.op == DP_SQ_MST)
        begin
            ma_reg <= PR_W'(dev_abs[MAG_W-1:0]);
            pr_reg <= '0;
        end
        else if (cmd.op == DP_MEAN_MST)
        begin
            ma_reg <= PR_W'(gain_reg);
            pr_reg <= '0;
        end
        else if (cmd.op == DP_V_MST)
        begin
            ma_reg <= PR_W'(g2_reg);
            pr_reg <= '0;
        end
        else if (mul_busy)
        begin
            if (mb_reg[0])
            begin
                pr_reg <= pr_reg + ma_reg;
            end
            ma_reg <= ma_reg << 1;
        end

        // restoring divider, one quotient bit per cycle
        if (cmd.op == DP_MEAN_DST)
        begin
            dvd_reg <= mean_dvd;
            ds_reg  <= DS_W'(n_reg) << MEAN_SHIFT;
            rem_reg <= '0;
        end
        else if (cmd.op == DP_D_DST)
        begin
            dvd_reg <= DV_W'(q_reg);
            ds_reg  <= DS_W'(n_reg);
            rem_reg <= '0;
        end
        else if (cmd.op == DP_V_DST)
        begin
            dvd_reg <= v_dvd;
            ds_reg  <= DS_W'(den_v_reg);
            rem_reg <= '0;
        end
        else if (div_busy)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DV_W-2:0], div_ge};
        end

        if (cmd.op == DP_MEAN_SAVE)
        begin
            mean_reg <= sum_reg[SUM_W-1] ? -$signed(dvd_reg[MEAN_W-1:0])
                                         : $signed(dvd_reg[MEAN_W-1:0]);
        end

        if (out_load)
        begin
            out_idx_reg  <= lane_reg;
            out_mean_reg <= mean_reg;
            out_var_reg  <= var_sat;
            out_last_reg <= lane_end;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.channel_index   = out_idx_reg;
    assign result.scaled_mean     = out_mean_reg;
    assign result.scaled_variance = out_var_reg;
    assign result.last            = out_last_reg;

    assign stat.close    = close;
    assign stat.k_end    = k_end;
    assign stat.lane_end = lane_end;
    assign stat.mul_busy = mul_busy;
    assign stat.div_busy = div_busy;
    assign stat.out_free = out_free;

    assert property (@(posedge clk) disable iff (!rst_n)
        close |=> !run_active_reg && n_reg >= NW'(2))
        else $error("run did not close with at least two samples");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_SQ_MST || cmd.op == DP_MEAN_MST || cmd.op == DP_V_MST) |-> !mul_busy)
        else $error("multiplier started while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_MEAN_DST || cmd.op == DP_D_DST || cmd.op == DP_V_DST) |-> !div_busy)
        else $error("divider started while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= NW'(MAX_SAMPLES))
        else $error("sample store overrun");
endmodule
`default_nettype wire

>>> sv/sensor_mean_variance_sampler_top.sv
// Sensor mean and variance sampler, top level.
// Channels: item (operation, lane0_raw..lane2_raw) in, result out, and cfg, a write
// channel of register index and data (sample_count, discard_count, channel_count, gain).
// An operation of 0 opens a run; each sample item after it is either dropped while the
// discard count runs down or stored as one row of the sample memory.
// While collecting, one item is taken per cycle. The item that completes the run starts
// the evaluation; no item is taken until the last channel result is in the output register.
// Evaluation per enabled channel, N kept samples: a sum pass, a squared deviation pass
// through the shift-and-add multiplier (each deviation at most 27 bits), the mean gain
// multiply, the variance gain multiply, three passes of the restoring divider, a step
// to save the mean, then the load of the output register.
// Results leave in channel order, last set on the final one.
// A result that is not taken holds the output register; the next channel waits for it.
// Reset clears run state to idle and loads the register defaults; the sample memory is
// not cleared, since only rows written in the current run are read.
`default_nettype none
module sensor_mean_variance_sampler_top import smvs_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    smvs_in_if.sink    item,
    smvs_out_if.source result,
    smvs_cfg_if.sink   cfg
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    smvs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    smvs_dpath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );
endmodule
`default_nettype wire
